// ===== hw/rtl/tdq_pkg.sv =====
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types, constants and the rounding function for the TPDF dither
// quantizer: controller states, datapath operations, command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

    // Generator and mixer constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    localparam int SAMPLE_W = 32;
    localparam int CODE_W   = 16;
    localparam int DRAW_W   = 24;
    localparam int DITHER_W = DRAW_W + 1;
    localparam int VALUE_W  = 48;
    localparam int FRAC_W   = 24;

    localparam logic [1:0] MUL_STEP_LAST = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_MUL,
        S_MIX,
        S_SUM,
        S_QUANT
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADV,
        OP_MUL,
        OP_MIX,
        OP_SUM,
        OP_QUANT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] mul_step;  // partial product index within one 64-bit multiply
        logic       mul_b;     // 0: first mixer constant, 1: second
        logic       second;    // 0: first draw of the frame, 1: second draw
    } cmd_t;

    typedef struct packed {
        logic out_free;        // output register empty or being taken
    } status_t;

    // Round a value in 2^-24 LSB units half away from zero, saturate to int16
    function automatic logic [CODE_W-1:0] round_sat(input logic [VALUE_W-1:0] value);
        logic               neg;
        logic [VALUE_W-1:0] mag_r;
        logic [VALUE_W-1:0] whole;
        logic [CODE_W-1:0]  code;
        neg = value[VALUE_W-1];
        // -v + half == ~v + half + 1
        mag_r = neg ? (~value + VALUE_W'((1 << (FRAC_W - 1)) + 1))
                    : (value + VALUE_W'(1 << (FRAC_W - 1)));
        whole = mag_r >> FRAC_W;
        if (neg) begin
            if (whole > VALUE_W'(32768)) begin
                code = 16'h8000;
            end else begin
                code = CODE_W'(~whole + VALUE_W'(1));
            end
        end else begin
            if (whole > VALUE_W'(32767)) begin
                code = 16'h7FFF;
            end else begin
                code = whole[CODE_W-1:0];
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpdf_dither_quantizer_stereo.sv =====
// One frame at a time: a new input word is accepted only in the idle state.
// The single 32x32 multiplier builds four
//   64-bit mixer products per frame from three partial products each.
// A held output word does not block the next input word; rounding waits
//   only if the previous result is still untaken.
// Reset (aresetn low, synchronous) clears the seed and the generator to zero.
// ----------------------------------------------------------------------------
// tpdf_dither_quantizer_stereo
// TPDF-dithered stereo quantizer from 2^24 fixed point to 16-bit codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdf_dither_quantizer_stereo
    import tdq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    // seed write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [63:0] cfg_data,     // dither_seed
    // input frames
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,      // [31:0] left_sample, [63:32] right_sample
    input  wire         s_tuser,      // restart
    // result frames
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,      // [15:0] left_code, [31:16] right_code
    output logic        m_tuser       // silent_frame
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdq_ctrl
// Sequencer for one frame: two generator draws, each with two 64-bit
// multiplies built from three 32x32 partial products, then sum and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ctrl
    import tdq_pkg::*;
(
    input  wire     aclk,
    input  wire     aresetn,
    input  wire     s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] mul_step_reg, mul_step_next;
    logic       mul_b_reg, mul_b_next;
    logic       second_reg, second_next;

    // Advance state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mul_step_reg <= 2'd0;
            mul_b_reg    <= 1'b0;
            second_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mul_step_reg <= mul_step_next;
            mul_b_reg    <= mul_b_next;
            second_reg   <= second_next;
        end
    end

    // Next state
    always_comb begin
        state_next    = state_reg;
        mul_step_next = mul_step_reg;
        mul_b_next    = mul_b_reg;
        second_next   = second_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next  = S_ADV;
                    mul_b_next  = 1'b0;
                    second_next = 1'b0;
                end
            end
            S_ADV: begin
                state_next    = S_MUL;
                mul_step_next = 2'd0;
            end
            S_MUL: begin
                if (mul_step_reg == MUL_STEP_LAST) begin
                    state_next    = S_MIX;
                    mul_step_next = 2'd0;
                end else begin
                    mul_step_next = mul_step_reg + 2'd1;
                end
            end
            S_MIX: begin
                if (!mul_b_reg) begin
                    state_next = S_MUL;
                    mul_b_next = 1'b1;
                end else if (!second_reg) begin
                    state_next  = S_ADV;
                    mul_b_next  = 1'b0;
                    second_next = 1'b1;
                end else begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                state_next = S_QUANT;
            end
            S_QUANT: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.mul_step = mul_step_reg;
        cmd.mul_b    = mul_b_reg;
        cmd.second   = second_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                end
            end
            S_ADV:   cmd.op = OP_ADV;
            S_MUL:   cmd.op = OP_MUL;
            S_MIX:   cmd.op = OP_MIX;
            S_SUM:   cmd.op = OP_SUM;
            S_QUANT: begin
                if (status.out_free) begin
                    cmd.op = OP_QUANT;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    // An accepted word always starts a generator advance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_ADV))
        else $error("accept did not start a draw");

    // The partial product counter only moves inside a multiply
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_step_reg != 2'd0) |-> (state_reg == S_MUL))
        else $error("multiply step outside multiply");

    // Results are written only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_QUANT) |-> status.out_free)
        else $error("output overwritten");

endmodule

`default_nettype wire

// ===== hw/rtl/tdq_datapath.sv =====
// ----------------------------------------------------------------------------
// tdq_datapath
// Generator state, shared 32x32 multiplier with accumulator, dither and
// per-channel rounding, plus the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_datapath
    import tdq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  wire         cfg_valid,
    input  wire  [63:0] cfg_data,
    input  wire  [63:0] s_tdata,
    input  wire         s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tuser
);

    logic [63:0]          seed_reg;
    logic [63:0]          st_reg, st_next;
    logic [63:0]          z_reg, z_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          prod_reg;
    logic [DRAW_W-1:0]    first_reg, first_next;
    logic [DITHER_W-1:0]  dither_reg, dither_next;
    logic [SAMPLE_W-1:0]  left_reg, right_reg;
    logic [VALUE_W-1:0]   val_l_reg, val_r_reg;
    logic [CODE_W-1:0]    left_code_reg, right_code_reg;
    logic                 silent_reg;
    logic                 m_valid_reg;

    logic [63:0]          st_adv;
    logic [63:0]          mul_const;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mix_w;
    logic [DRAW_W-1:0]    draw;

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 64'd0;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    // Multiplier operands: lo*lo, lo*hi, hi*lo
    assign mul_const = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
    always_comb begin
        unique case (cmd.mul_step)
            2'd1: begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[63:32];
            end
            2'd2: begin
                mul_a = z_reg[63:32];
                mul_b = mul_const[31:0];
            end
            default: begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign st_adv = st_reg + GOLDEN_GAMMA;
    assign mix_w  = acc_reg ^ (acc_reg >> 31);
    assign draw   = mix_w[63:40];

    // Generator, accumulator and dither
    always_comb begin
        st_next     = st_reg;
        z_next      = z_reg;
        acc_next    = acc_reg;
        first_next  = first_reg;
        dither_next = dither_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                if (s_tuser) begin
                    st_next = seed_reg;
                end
            end
            OP_ADV: begin
                st_next = st_adv;
                z_next  = st_adv ^ (st_adv >> 30);
            end
            OP_MUL: begin
                if (cmd.mul_step == 2'd1) begin
                    acc_next = prod_reg;
                end else if (cmd.mul_step != 2'd0) begin
                    acc_next[63:32] = acc_reg[63:32] + prod_reg[31:0];
                end
            end
            OP_MIX: begin
                if (!cmd.mul_b) begin
                    z_next = acc_reg ^ (acc_reg >> 27);
                end else if (!cmd.second) begin
                    first_next = draw;
                end else begin
                    dither_next = {1'b0, first_reg} - {1'b0, draw};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= 64'd0;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg      <= z_next;
        acc_reg    <= acc_next;
        first_reg  <= first_next;
        dither_reg <= dither_next;
    end

    // Latch samples on accept, form sample*2^15 + dither
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            left_reg  <= s_tdata[31:0];
            right_reg <= s_tdata[63:32];
        end
        if (cmd.op == OP_SUM) begin
            val_l_reg <= {left_reg[SAMPLE_W-1], left_reg, 15'd0}
                       + {{(VALUE_W-DITHER_W){dither_reg[DITHER_W-1]}}, dither_reg};
            val_r_reg <= {right_reg[SAMPLE_W-1], right_reg, 15'd0}
                       + {{(VALUE_W-DITHER_W){dither_reg[DITHER_W-1]}}, dither_reg};
        end
    end

    // Round and saturate each channel, or give zero codes for a silent frame, and hold the result word
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_QUANT) begin
            if (left_reg == 32'd0 && right_reg == 32'd0) begin
                left_code_reg  <= 16'd0;
                right_code_reg <= 16'd0;
                silent_reg     <= 1'b1;
            end else begin
                left_code_reg  <= round_sat(val_l_reg);
                right_code_reg <= round_sat(val_r_reg);
                silent_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_QUANT) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = {right_code_reg, left_code_reg};
    assign m_tuser         = silent_reg;

    // Restart reloads the generator from the seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD && s_tuser) |=> (st_reg == $past(seed_reg)))
        else $error("restart did not reload generator");

    // Without restart the accept leaves the generator alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD && !s_tuser) |=> $stable(st_reg))
        else $error("generator moved on accept");

    // A new result word appears only after a rounding step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op == OP_QUANT))
        else $error("result word without rounding");

endmodule

`default_nettype wire
